/* rtl/aliq_pkg.sv */
// ----------------------------------------------------------------------------
// aliq_pkg: shared constants for the aliquot sum unit
// Result width and the upper bound on accepted input numbers.
// ----------------------------------------------------------------------------
`default_nettype none

package aliq_pkg;

  localparam int SUM_WIDTH = 53;

  localparam logic [63:0] VALUE_LIMIT = 64'd1000000000000000;

endpackage

`default_nettype wire

/* rtl/aliq_if.sv */
// ----------------------------------------------------------------------------
// aliq_if: valid/ready channels of the aliquot sum unit
// One interface for the input number word, one for the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface aliq_in_if #(
  parameter int NUMBER_WIDTH = 50
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface aliq_out_if;
  logic                           valid;
  logic                           ready;
  logic [aliq_pkg::SUM_WIDTH-1:0] divisor_sum;
  logic                           too_large;

  modport source (output valid, output divisor_sum, output too_large, input ready);
  modport sink   (input valid, input divisor_sum, input too_large, output ready);
endinterface

`default_nettype wire

/* rtl/aliquot_sum_unit.sv */
// ----------------------------------------------------------------------------
// aliquot_sum_unit: sum of proper divisors by trial division
// Bit-serial floor square root, then one restoring division per trial divisor.
// ----------------------------------------------------------------------------
// Steps: S_ROOT, then S_DIV, S_ACC_D and S_ACC_Q for each trial divisor up to
//   floor(sqrt(value)); a number above 10^15 goes straight to S_DONE.
// Throughput: one word at a time, set by the radix-2 divider producing one
//   quotient bit per cycle; a new word is taken while a result waits.
// Reset: synchronous, active low; clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module aliquot_sum_unit #(
  parameter int NUMBER_WIDTH = 50
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aliq_in_if.sink    in_word,
  aliq_out_if.source out_word
);

  localparam int RW = (NUMBER_WIDTH + 1) / 2;
  localparam int NE = 2 * RW;
  localparam int CW = $clog2(NUMBER_WIDTH);
  localparam int SW = aliq_pkg::SUM_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_DIV,
    S_ACC_D,
    S_ACC_Q,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [NUMBER_WIDTH-1:0] val_r;
  logic [NE-1:0]           nsh_r;
  logic [RW-1:0]           rrem_r;
  logic [RW-1:0]           root_r;
  logic [RW-1:0]           d_r;
  logic [RW:0]             drem_r;
  logic [NUMBER_WIDTH-1:0] qsh_r;
  logic [CW-1:0]           cnt_r;
  logic [SW-1:0]           acc_r;
  logic                    tl_r;
  logic                    out_valid_r;
  logic [SW-1:0]           out_sum_r;
  logic                    out_tl_r;

  logic [RW+1:0]           rrem_s;
  logic [RW+1:0]           rtrial;
  logic                    rge;
  logic [RW+1:0]           rrem_nxt;
  logic [RW-1:0]           root_nxt;
  logic [RW:0]             drem_s;
  logic                    dge;
  logic                    exact;
  logic                    out_load;

  always_comb begin
    rrem_s   = {rrem_r, nsh_r[NE-1 -: 2]};
    rtrial   = {root_r, 2'b01};
    rge      = rrem_s >= rtrial;
    rrem_nxt = rge ? rrem_s - rtrial : rrem_s;
    root_nxt = {root_r[RW-2:0], rge};
    drem_s   = {drem_r[RW-1:0], qsh_r[NUMBER_WIDTH-1]};
    dge      = drem_s >= {1'b0, d_r};
    exact    = drem_r == '0;
    out_load = (state_r == S_DONE) && (!out_valid_r || out_word.ready);
  end

  assign in_word.ready        = state_r == S_IDLE;
  assign out_word.valid       = out_valid_r;
  assign out_word.divisor_sum = out_sum_r;
  assign out_word.too_large   = out_tl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_sum_r   <= acc_r;
        out_tl_r    <= tl_r;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_word.valid) begin
            val_r  <= in_word.value;
            nsh_r  <= NE'(in_word.value);
            rrem_r <= '0;
            root_r <= '0;
            cnt_r  <= '0;
            acc_r  <= '0;
            if (64'(in_word.value) > aliq_pkg::VALUE_LIMIT) begin
              tl_r    <= 1'b1;
              state_r <= S_DONE;
            end else begin
              tl_r    <= 1'b0;
              state_r <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          rrem_r <= rrem_nxt[RW-1:0];
          root_r <= root_nxt;
          nsh_r  <= {nsh_r[NE-3:0], 2'b00};
          if (cnt_r == CW'(RW - 1)) begin
            d_r    <= RW'(1);
            qsh_r  <= val_r;
            drem_r <= '0;
            cnt_r  <= '0;
            state_r <= (root_nxt == '0) ? S_DONE : S_DIV;
          end else begin
            cnt_r  <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          drem_r <= dge ? drem_s - {1'b0, d_r} : drem_s;
          qsh_r  <= {qsh_r[NUMBER_WIDTH-2:0], dge};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CW'(NUMBER_WIDTH - 1)) begin
            state_r <= S_ACC_D;
          end
        end
        S_ACC_D: begin
          if (exact && NUMBER_WIDTH'(d_r) != val_r) begin
            acc_r <= acc_r + SW'(d_r);
          end
          state_r <= S_ACC_Q;
        end
        S_ACC_Q: begin
          if (exact && qsh_r != NUMBER_WIDTH'(d_r) && qsh_r != val_r) begin
            acc_r <= acc_r + SW'(qsh_r);
          end
          if (d_r == root_r) begin
            state_r <= S_DONE;
          end else begin
            d_r    <= d_r + 1'b1;
            qsh_r  <= val_r;
            drem_r <= '0;
            cnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sim/aliquot_sum_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aliquot_sum_unit_test: self-checking bench for the aliquot sum unit
// A table of corner numbers (zero, one, primes, squares, perfect numbers,
// values above the 10^15 bound) is followed by random numbers. Most
// are small, because the unit tries every divisor up to the square root and
// its latency grows with that root. Each accepted word is predicted by the
// table or by a local trial-division model; each result is compared with the
// oldest prediction. Both channels idle in random bursts, except at the end.
// ----------------------------------------------------------------------------

module aliquot_sum_unit_test;

  localparam int NW       = 50;
  localparam int NPROBE   = 22;
  localparam int NRANDOM  = 78;
  localparam int NCALM    = 20;
  localparam int TAIL     = 64;
  localparam longint unsigned DEADLINE_NS = 64'd1_000_000_000;

  localparam logic [NW-1:0] NUMBER_MAX = {NW{1'b1}};
  localparam logic [NW-1:0] LIMIT      = aliq_pkg::VALUE_LIMIT[NW-1:0];

  typedef struct packed {
    logic [aliq_pkg::SUM_WIDTH-1:0] sum;
    logic                           refused;
  } outcome_t;

  typedef struct packed {
    logic [NW-1:0]                  number;
    bit                             known;
    logic [aliq_pkg::SUM_WIDTH-1:0] sum;
    logic                           refused;
  } probe_t;

  logic clk;
  logic rst_n;
  bit   calm;
  int   errors;
  int   words_sent;
  int   words_refused;
  int   results_seen;
  logic [NW-1:0] largest_summed;

  outcome_t pending_sums [$];

  aliq_in_if #(.NUMBER_WIDTH(NW)) number_ch ();
  aliq_out_if                     sum_ch ();

  aliquot_sum_unit #(.NUMBER_WIDTH(NW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (number_ch),
    .out_word (sum_ch)
  );

  probe_t probes [NPROBE] = '{
    '{50'd0,               1'b1, 53'd0, 1'b0},
    '{50'd1,               1'b1, 53'd0, 1'b0},
    '{50'd2,               1'b0, 53'd0, 1'b0},
    '{50'd3,               1'b0, 53'd0, 1'b0},
    '{50'd4,               1'b0, 53'd0, 1'b0},
    '{50'd6,               1'b0, 53'd0, 1'b0},
    '{50'd9,               1'b0, 53'd0, 1'b0},
    '{50'd12,              1'b0, 53'd0, 1'b0},
    '{50'd28,              1'b0, 53'd0, 1'b0},
    '{50'd97,              1'b0, 53'd0, 1'b0},
    '{50'd496,             1'b0, 53'd0, 1'b0},
    '{50'd1024,            1'b0, 53'd0, 1'b0},
    '{50'd4095,            1'b0, 53'd0, 1'b0},
    '{50'd8128,            1'b0, 53'd0, 1'b0},
    '{50'd65521,           1'b0, 53'd0, 1'b0},
    '{50'd999999,          1'b0, 53'd0, 1'b0},
    '{50'd1048576,         1'b0, 53'd0, 1'b0},
    '{50'd4194304,         1'b0, 53'd0, 1'b0},
    '{LIMIT + 50'd1,       1'b1, 53'd0, 1'b1},
    '{LIMIT + 50'd2,       1'b1, 53'd0, 1'b1},
    '{50'h3FFFF00000000,   1'b1, 53'd0, 1'b1},
    '{NUMBER_MAX,          1'b1, 53'd0, 1'b1}
  };

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] step;
    rem  = n;
    root = 64'd0;
    step = 64'd1 << 62;
    while (step > rem) step >>= 2;
    while (step != 64'd0) begin
      if (rem >= root + step) begin
        rem  = rem - (root + step);
        root = (root >> 1) + step;
      end else begin
        root >>= 1;
      end
      step >>= 2;
    end
    return root;
  endfunction

  function automatic outcome_t predict_outcome(input logic [NW-1:0] number);
    outcome_t    res;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] acc;
    n   = 64'(number);
    acc = 64'd0;
    res.refused = (n > aliq_pkg::VALUE_LIMIT);
    if (!res.refused) begin
      r = floor_root(n);
      for (logic [63:0] d = 64'd1; d <= r; d++) begin
        if (n % d == 64'd0) begin
          q = n / d;
          if (d != n) acc += d;
          if (q != d && q != n) acc += q;
        end
      end
    end
    res.sum = acc[aliq_pkg::SUM_WIDTH-1:0];
    return res;
  endfunction

  function automatic logic [NW-1:0] pick_number();
    logic [63:0] raw;
    int          pick;
    int          root;
    pick = $urandom_range(0, 99);
    raw  = {$urandom, $urandom} & 64'(NUMBER_MAX);
    if (pick < 30) begin
      if (raw <= 64'(LIMIT)) raw = 64'(LIMIT) + 64'd1 + raw % (64'(NUMBER_MAX) - 64'(LIMIT));
      return raw[NW-1:0];
    end else if (pick < 70) begin
      return NW'($urandom_range(0, 4095));
    end else if (pick < 82) begin
      root = $urandom_range(2, 511);
      return NW'(root * root);
    end else if (pick < 96) begin
      return NW'($urandom_range(0, (1 << 20) - 1));
    end
    return NW'($urandom_range(0, (1 << 22) - 1));
  endfunction

  task automatic offer_number(input logic [NW-1:0] number);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      number_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    number_ch.valid <= 1'b1;
    number_ch.value <= number;
    do @(posedge clk); while (!number_ch.ready);
    words_sent++;
    if (number > LIMIT) words_refused++;
    else if (number > largest_summed) largest_summed = number;
  endtask

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #(DEADLINE_NS);
    $display("%0t: timeout with %0d results outstanding", $time, pending_sums.size());
    $display("aliquot_sum_unit_test: errors");
    $finish;
  end

  // hold ready low in short bursts until the calm tail
  initial begin
    sum_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        sum_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      sum_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && sum_ch.valid && sum_ch.ready) begin
      results_seen++;
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: divisor_sum %0d too_large %0b",
                 $time, sum_ch.divisor_sum, sum_ch.too_large);
      end else begin
        want = pending_sums.pop_front();
        if (sum_ch.divisor_sum !== want.sum) begin
          errors++;
          $display("%0t: divisor_sum mismatch: expected %0d, got %0d",
                   $time, want.sum, sum_ch.divisor_sum);
        end
        if (sum_ch.too_large !== want.refused) begin
          errors++;
          $display("%0t: too_large mismatch: expected %0b, got %0b",
                   $time, want.refused, sum_ch.too_large);
        end
      end
    end
  end

  initial begin
    logic [NW-1:0] number;
    outcome_t      want;
    rst_n           <= 1'b0;
    calm            = 1'b0;
    errors          = 0;
    words_sent      = 0;
    words_refused   = 0;
    results_seen    = 0;
    largest_summed  = '0;
    number_ch.valid <= 1'b0;
    number_ch.value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) begin
      offer_number(probes[i].number);
      if (probes[i].known) begin
        want.sum     = probes[i].sum;
        want.refused = probes[i].refused;
      end else begin
        want = predict_outcome(probes[i].number);
      end
      pending_sums.push_back(want);
    end

    for (int i = 0; i < NRANDOM; i++) begin
      if (i == NRANDOM - NCALM) calm = 1'b1;
      number = pick_number();
      offer_number(number);
      pending_sums.push_back(predict_outcome(number));
    end
    number_ch.valid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("covered %0d words (%0d above the 10^15 bound), %0d results checked",
             words_sent, words_refused, results_seen);
    $display("largest number summed: %0d", largest_summed);
    if (errors == 0) begin
      $display("aliquot_sum_unit_test: clean");
    end else begin
      $display("aliquot_sum_unit_test: errors");
    end
    $finish;
  end

endmodule
